@@ rtl/mavg_pkg.sv @@
// shared widths and constants for the moving average block
`timescale 1ns / 1ps
package mavg_pkg;

	localparam int CNT_W = 16;          // daily count
	localparam int SUM_W = 24;          // window sum
	localparam int AVG_W = 16;          // average
	localparam int PCT_W = 32;          // signed q8 percent change
	localparam int CFG_W = 8;           // window size register
	localparam int DIV_W = 32;          // divider dividend / quotient
	localparam int DVS_W = 16;          // divider divisor
	localparam int SCL_W = 15;          // width of the percent scale
	localparam int PRD_W = AVG_W + SCL_W;

	localparam logic [CFG_W-1:0] WIN_RESET = 8'd7;
	localparam logic [SUM_W-1:0] SUM_MAX   = 24'hFFFFFF;
	localparam logic [AVG_W-1:0] AVG_MAX   = 16'hFFFF;
	// 100 percent times 256
	localparam logic [SCL_W-1:0] PCT_SCALE = 15'd25600;

endpackage

@@ rtl/mavg_ram.sv @@
// generic simple dual port ram with registered read
`timescale 1ns / 1ps
module mavg_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 255,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                   clk,
	input  logic                   we,
	input  logic [ADDR_W-1:0]      waddr,
	input  logic [WIDTH-1:0]       wdata,
	input  logic                   re,
	input  logic [ADDR_W-1:0]      raddr,
	output logic [WIDTH-1:0]       rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/mavg_div.sv @@
// radix-2 restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module mavg_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [mavg_pkg::DIV_W-1:0]    dividend,
	input  logic [mavg_pkg::DVS_W-1:0]    divisor,
	output logic                          done,
	output logic [mavg_pkg::DIV_W-1:0]    quotient
);
	localparam int CNT_W = $clog2(mavg_pkg::DIV_W);
	localparam int DW    = mavg_pkg::DIV_W;
	localparam int VW    = mavg_pkg::DVS_W;

	logic [DW-1:0]    quo_q;
	logic [VW-1:0]    rem_q;
	logic [VW-1:0]    dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [VW+1:0] trial;
	logic          fits;
	logic [VW-1:0] rem_next;

	// shift in the next dividend bit and try a subtract
	assign trial    = {1'b0, rem_q, quo_q[DW-1]} - {2'b00, dvs_q};
	assign fits     = ~trial[VW+1];
	assign rem_next = fits ? trial[VW-1:0] : {rem_q[VW-2:0], quo_q[DW-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(DW - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DW - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DW-2:0], fits};
			rem_q <= rem_next;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

@@ rtl/moving_average_with_change.sv @@
// top level: window sum, average and percent change sequencer
`timescale 1ns / 1ps
// Moving average with percent change. Each transfer in carries one unsigned
// daily count; each gives exactly one result: the sum of the last window_size
// counts (all counts so far during warm-up, saturating at 24 bits), that sum
// divided by window_size (saturating at 16 bits), and the percent change from
// the previous average as a signed Q8 value truncated toward zero, or the
// infinite flag when the previous average is zero (on the first item, only
// when its average is nonzero). The block works on one item at a time:
// in_ready is high only while it waits for an item. The result of an item is
// offered after the average division and, unless the first item or a zero
// previous average skips it, after the percent change division; in_ready
// returns in the same cycle. Both divisions run on the shared 32-step radix-2
// divider. A finished result sits in an output register so the next item can
// be taken while it waits; that next item then holds in its last step until
// the register is free, which delays its result by the wait. window_size 0
// acts as 1, values above MAX_WINDOW act as MAX_WINDOW; write it only while
// the block is idle. The count history ram needs no clearing after reset.
module moving_average_with_change #(
	parameter int MAX_WINDOW = 255
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [mavg_pkg::CFG_W-1:0]           cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [mavg_pkg::CNT_W-1:0]           daily_count,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [mavg_pkg::SUM_W-1:0]           moving_sum,
	output logic [mavg_pkg::AVG_W-1:0]           moving_average,
	output logic signed [mavg_pkg::PCT_W-1:0]    change_percent_q8,
	output logic                                 change_infinite
);
	localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int CW = mavg_pkg::CFG_W;
	localparam int SW = mavg_pkg::SUM_W;
	localparam int VW = mavg_pkg::AVG_W;
	localparam int PW = mavg_pkg::PCT_W;
	localparam int XW = mavg_pkg::CNT_W;
	localparam int DW = mavg_pkg::DIV_W;
	localparam int RW = mavg_pkg::PRD_W;

	localparam logic [CW:0]   MAXW_EXT = (CW + 1)'(MAX_WINDOW);
	localparam logic [CW-1:0] MAXW_CFG = CW'(MAX_WINDOW);
	localparam logic [AW-1:0] LAST_SLOT = AW'(MAX_WINDOW - 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_UPD  = 3'd1;
	localparam logic [2:0] ST_D1S  = 3'd2;
	localparam logic [2:0] ST_D1W  = 3'd3;
	localparam logic [2:0] ST_CHK  = 3'd4;
	localparam logic [2:0] ST_D2S  = 3'd5;
	localparam logic [2:0] ST_D2W  = 3'd6;
	localparam logic [2:0] ST_FIN  = 3'd7;

	logic [2:0]    state_q;
	logic [CW-1:0] window_size_q;
	logic [AW-1:0] write_slot_q;
	logic [CW-1:0] items_seen_q;
	logic [SW-1:0] window_total_q;
	logic [VW-1:0] prev_avg_q;
	logic          first_q;
	logic [CW-1:0] n_q;
	logic [XW-1:0] x_q;
	logic [VW-1:0] avg_q;
	logic          neg_q;
	logic [RW-1:0] prod_q;
	logic [PW-1:0] pct_q;
	logic          inf_q;

	logic          out_valid_q;
	logic [SW-1:0] sum_out_q;
	logic [VW-1:0] avg_out_q;
	logic [PW-1:0] pct_out_q;
	logic          inf_out_q;

	logic [CW-1:0] n_eff;
	logic [CW:0]   back_raw;
	logic [CW:0]   back_wrap;
	logic          accept;
	logic [XW-1:0] old_count;
	logic [SW-1:0] base_total;
	logic [SW:0]   new_total;
	logic          full_window;
	logic [VW-1:0] mag;
	logic          load_out;

	logic          div_start;
	logic [DW-1:0] div_dividend;
	logic [VW-1:0] div_divisor;
	logic          div_done;
	logic [DW-1:0] div_quot;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);

	// window size clamped to one .. MAX_WINDOW
	always_comb begin
		n_eff = window_size_q;
		if (window_size_q == '0) begin
			n_eff = CW'(1);
		end else if (window_size_q > MAXW_CFG) begin
			n_eff = MAXW_CFG;
		end
	end

	// slot of the count that leaves the window
	assign back_raw  = (CW + 1)'(write_slot_q) + MAXW_EXT - {1'b0, n_eff};
	assign back_wrap = (back_raw >= MAXW_EXT) ? (back_raw - MAXW_EXT) : back_raw;

	mavg_ram #(
		.WIDTH (XW),
		.DEPTH (MAX_WINDOW)
	) u_hist (
		.clk   (clk),
		.we    (state_q == ST_UPD),
		.waddr (write_slot_q),
		.wdata (x_q),
		.re    (accept),
		.raddr (back_wrap[AW-1:0]),
		.rdata (old_count)
	);

	assign full_window = (items_seen_q >= n_q);

	always_comb begin
		base_total = window_total_q;
		if (full_window) begin
			base_total = (SW'(old_count) > window_total_q) ? '0
				: (window_total_q - SW'(old_count));
		end
	end
	assign new_total = {1'b0, base_total} + (SW + 1)'(x_q);

	assign mag = (avg_q < prev_avg_q) ? (prev_avg_q - avg_q) : (avg_q - prev_avg_q);

	// the two divisions share one divider
	assign div_start    = (state_q == ST_D1S) || (state_q == ST_D2S);
	assign div_dividend = (state_q == ST_D2S) ? DW'(prod_q) : DW'(window_total_q);
	assign div_divisor  = (state_q == ST_D2S) ? prev_avg_q : VW'(n_q);

	mavg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quot)
	);

	assign load_out = (state_q == ST_FIN) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			window_size_q  <= mavg_pkg::WIN_RESET;
			write_slot_q   <= '0;
			items_seen_q   <= '0;
			window_total_q <= '0;
			prev_avg_q     <= '0;
			first_q        <= 1'b1;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				window_size_q <= cfg_data;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					window_total_q <= new_total[SW] ? mavg_pkg::SUM_MAX : new_total[SW-1:0];
					write_slot_q   <= (write_slot_q == LAST_SLOT) ? '0 : write_slot_q + 1'b1;
					if (!full_window) begin
						items_seen_q <= items_seen_q + 1'b1;
					end
					state_q <= ST_D1S;
				end
				ST_D1S: state_q <= ST_D1W;
				ST_D1W: begin
					if (div_done) begin
						state_q <= ST_CHK;
					end
				end
				ST_CHK: begin
					if (first_q || prev_avg_q == '0) begin
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_D2S;
					end
				end
				ST_D2S: state_q <= ST_D2W;
				ST_D2W: begin
					if (div_done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (load_out) begin
						prev_avg_q <= avg_q;
						first_q    <= 1'b0;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q <= daily_count;
			n_q <= n_eff;
		end
		if (state_q == ST_D1W && div_done) begin
			avg_q <= (div_quot[DW-1:VW] != '0) ? mavg_pkg::AVG_MAX : div_quot[VW-1:0];
		end
		if (state_q == ST_CHK) begin
			neg_q  <= (avg_q < prev_avg_q);
			prod_q <= RW'(mag) * RW'(mavg_pkg::PCT_SCALE);
			pct_q  <= '0;
			if (first_q) begin
				inf_q <= (avg_q != '0);
			end else begin
				inf_q <= (prev_avg_q == '0);
			end
		end
		if (state_q == ST_D2W && div_done) begin
			pct_q <= neg_q ? (PW'(0) - PW'(div_quot)) : PW'(div_quot);
		end
		if (load_out) begin
			sum_out_q <= window_total_q;
			avg_out_q <= avg_q;
			pct_out_q <= pct_q;
			inf_out_q <= inf_q;
		end
	end

	assign out_valid         = out_valid_q;
	assign moving_sum        = sum_out_q;
	assign moving_average    = avg_out_q;
	assign change_percent_q8 = signed'(pct_out_q);
	assign change_infinite   = inf_out_q;

`ifndef NO_ASSERTIONS
	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("input taken again right after a transfer");

	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_D1W || state_q == ST_D2W))
		else $error("divider finished outside a wait state");

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		(AW + 1)'(write_slot_q) < (AW + 1)'(MAX_WINDOW))
		else $error("write slot beyond the history depth");

	a_inf_zero_pct: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(change_infinite && change_percent_q8 != '0))
		else $error("infinite change with nonzero percent");
`endif

endmodule

@@ tb/sv/testbench.sv @@
// testbench for the moving average block with window sum, average and percent change
`timescale 1ns / 1ps
module testbench;

	localparam int HIST_DEPTH = 255;
	localparam int IDLE_LIMIT = 4000;

	typedef struct packed {
		logic [mavg_pkg::SUM_W-1:0]        sum;
		logic [mavg_pkg::AVG_W-1:0]        avg;
		logic signed [mavg_pkg::PCT_W-1:0] pct;
		logic                              inf;
	} window_result_t;

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              cfg_we = 1'b0;
	logic [mavg_pkg::CFG_W-1:0]        cfg_data = '0;
	logic                              in_valid = 1'b0;
	logic                              in_ready;
	logic [mavg_pkg::CNT_W-1:0]        daily_count = '0;
	logic                              out_valid;
	logic                              out_ready = 1'b0;
	logic [mavg_pkg::SUM_W-1:0]        moving_sum;
	logic [mavg_pkg::AVG_W-1:0]        moving_average;
	logic signed [mavg_pkg::PCT_W-1:0] change_percent_q8;
	logic                              change_infinite;

	// predicted state of the block
	logic [mavg_pkg::CNT_W-1:0] day_hist [HIST_DEPTH];
	int unsigned                hist_slot = 0;
	int unsigned                days_held = 0;
	int unsigned                run_total = 0;
	int unsigned                last_avg = 0;
	bit                         no_prior = 1'b1;
	logic [mavg_pkg::CFG_W-1:0] win_cfg = mavg_pkg::WIN_RESET;

	window_result_t window_results[$];
	window_result_t want;
	int unsigned    mismatches = 0;

	moving_average_with_change #(
		.MAX_WINDOW(HIST_DEPTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.daily_count(daily_count),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.moving_sum(moving_sum),
		.moving_average(moving_average),
		.change_percent_q8(change_percent_q8),
		.change_infinite(change_infinite)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// window sum, average and percent change for one accepted day
	function automatic void advance_window(input logic [mavg_pkg::CNT_W-1:0] cnt);
		int unsigned    n;
		int unsigned    back;
		int unsigned    total;
		int unsigned    avg;
		longint         diff;
		longint         q;
		window_result_t r;
		n = (win_cfg == 0) ? 1 : int'(win_cfg);
		total = run_total;
		if (days_held >= n) begin
			back = (hist_slot + HIST_DEPTH - n) % HIST_DEPTH;
			// clamp at zero when the oldest count exceeds the sum
			total = (day_hist[back] > total) ? 0 : total - day_hist[back];
		end else begin
			days_held++;
		end
		total = total + cnt;
		if (total > mavg_pkg::SUM_MAX)
			total = mavg_pkg::SUM_MAX;
		day_hist[hist_slot] = cnt;
		hist_slot = (hist_slot + 1) % HIST_DEPTH;
		run_total = total;
		avg = total / n;
		if (avg > mavg_pkg::AVG_MAX)
			avg = mavg_pkg::AVG_MAX;
		r.sum = total[mavg_pkg::SUM_W-1:0];
		r.avg = avg[mavg_pkg::AVG_W-1:0];
		r.pct = '0;
		r.inf = 1'b0;
		if (no_prior) begin
			r.inf = (avg != 0);
		end else if (last_avg == 0) begin
			r.inf = 1'b1;
		end else begin
			diff = longint'(avg) - longint'(last_avg);
			q = (diff * longint'(mavg_pkg::PCT_SCALE)) / longint'(last_avg);
			r.pct = q[mavg_pkg::PCT_W-1:0];
		end
		last_avg = avg;
		no_prior = 1'b0;
		window_results = {window_results, r};
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] exp_val);
		mismatches++;
		$display("mismatch %s: got %0h, want %0h at %0t", what, got, exp_val, $realtime);
	endtask

	task automatic send_day(input logic [mavg_pkg::CNT_W-1:0] cnt);
		@(negedge clk);
		in_valid <= 1'b1;
		daily_count <= cnt;
		do @(posedge clk); while (!in_ready);
		advance_window(cnt);
	endtask

	task automatic pause_sender(input int unsigned cycles);
		@(negedge clk);
		in_valid <= 1'b0;
		repeat (cycles - 1) @(negedge clk);
	endtask

	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (window_results.size() != 0) @(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_window(input logic [mavg_pkg::CFG_W-1:0] size);
		drain_results();
		cfg_we <= 1'b1;
		cfg_data <= size;
		@(posedge clk);
		win_cfg = size;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// first day with zero average, zero previous average, underflow clamp, average saturation
	task automatic test_warmup_and_clamp();
		write_window(8'd3);
		send_day(16'd0);
		send_day(16'd0);
		send_day(16'hFFFF);
		write_window(8'd1);
		send_day(16'd0);
		send_day(16'd0);
		// grows back over a count already dropped, so the sum clamps at zero
		write_window(8'd3);
		send_day(16'd0);
		repeat (3) send_day(16'hFFFF);
		// stale sum over a window of one drives the average past 16 bits
		write_window(8'd1);
		send_day(16'hFFFF);
		send_day(16'd1);
	endtask

	task automatic test_window_extremes();
		write_window(8'd1);
		send_day(16'hFFFF);
		send_day(16'd0);
		send_day(16'd1);
		write_window(8'd0);
		send_day(16'd40000);
		send_day(16'd5);
		send_day(16'd0);
		write_window(8'd255);
		send_day(16'hFFFF);
		send_day(16'hAAAA);
		send_day(16'h5555);
		send_day(16'd0);
	endtask

	task automatic test_random_days();
		int unsigned                burst;
		int unsigned                span;
		int unsigned                style;
		logic [mavg_pkg::CFG_W-1:0] size;
		logic [mavg_pkg::CNT_W-1:0] day;
		logic [mavg_pkg::CNT_W-1:0] last_day;
		burst = 0;
		last_day = '0;
		for (int phase = 0; phase < 10; phase++) begin
			span = $urandom_range(15, 40);
			case (phase)
				0: begin
					size = 8'd255;
					span = 100;
				end
				1: size = 8'd1;
				2: size = 8'd0;
				9: begin
					size = 8'd255;
					span = 130;
				end
				default: begin
					style = $urandom_range(0, 2);
					if (style == 0)
						size = 8'($urandom_range(2, 16));
					else if (style == 1)
						size = 8'($urandom_range(1, 255));
					else
						size = mavg_pkg::WIN_RESET;
				end
			endcase
			write_window(size);
			repeat (span) begin
				if (burst == 0) begin
					pause_sender($urandom_range(1, 90));
					burst = $urandom_range(1, 12);
				end
				style = $urandom_range(0, 19);
				if (style < 8)
					day = 16'($urandom());
				else if (style < 12)
					day = 16'($urandom_range(0, 3));
				else if (style < 15)
					day = $urandom_range(0, 1) ? '1 : '0;
				else
					day = last_day + 16'($urandom_range(0, 64)) - 16'd32;
				send_day(day);
				last_day = day;
				burst--;
			end
		end
	endtask

	// receiver: stretches of full throughput, random stalls and long stalls
	initial begin : result_stall
		int unsigned mode;
		int unsigned span;
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(1, 60);
			repeat (span) begin
				@(negedge clk);
				case (mode) inside
					0, 1: out_ready <= 1'b1;
					2: out_ready <= 1'($urandom_range(0, 1));
					default: out_ready <= 1'b0;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (window_results.size() == 0) begin
				report_mismatch("result with none expected", 32'(moving_sum), '0);
			end else begin
				want = window_results.pop_front();
				if (moving_sum !== want.sum)
					report_mismatch("moving_sum", 32'(moving_sum), 32'(want.sum));
				if (moving_average !== want.avg)
					report_mismatch("moving_average", 32'(moving_average), 32'(want.avg));
				if (change_percent_q8 !== want.pct)
					report_mismatch("change_percent_q8", change_percent_q8, want.pct);
				if (change_infinite !== want.inf)
					report_mismatch("change_infinite", 32'(change_infinite), 32'(want.inf));
			end
		end
	end

	// ends the run when no transfer of any kind happens for too long
	initial begin : watchdog
		int unsigned idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
				idle = 0;
			else
				idle++;
		end
		$display("status: fail");
		$finish;
	end

	initial begin
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		test_warmup_and_clamp();
		test_window_extremes();
		test_random_days();
		drain_results();
		repeat (100) @(posedge clk);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
